FILE: rtl/skt_pkg.sv
package skt_pkg;

  // Word field widths
  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 24;
  localparam int TYPE_W   = 5;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 8;
  localparam int COUNT_W  = 9;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_SPARE  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_TYPE  = 3'd4;

  // Result type/position source
  localparam logic [1:0] RSEL_ZERO  = 2'd0;
  localparam logic [1:0] RSEL_PROBE = 2'd1;
  localparam logic [1:0] RSEL_NEW   = 2'd2;

  typedef struct packed {
    logic                load;       // capture word, start search
    logic                probe_rd;   // read entry at search midpoint
    logic                probe_upd;  // narrow search window
    logic                res_set;    // latch result code
    logic [STATUS_W-1:0] res_code;
    logic [1:0]          res_sel;
    logic                mv_init_ins;
    logic                mv_init_del;
    logic                ins_rd;     // read entry below move index
    logic                ins_wr;     // write it at move index, step down
    logic                del_rd;     // read entry above move index
    logic                del_wr;     // write it at move index, step up
    logic                new_wr;     // store new entry, count up
    logic                cnt_dec;
    logic                out_load;
  } skt_cmd_t;

  typedef struct packed {
    logic              srch_more;
    logic              hit;
    logic              bad_type;
    logic              full;
    logic [FUNC_W-1:0] func;
    logic              ins_more;
    logic              del_more;
    logic              out_free;
  } skt_stat_t;

endpackage

FILE: rtl/skt_in_if.sv
interface skt_in_if;
  logic                            valid;
  logic                            ready;
  logic [skt_pkg::FUNC_W-1:0]      func;
  logic [skt_pkg::KEY_W-1:0]       key;
  logic [skt_pkg::TYPE_W-1:0]      entry_type;

  modport source (output valid, func, key, entry_type, input ready);
  modport sink   (input valid, func, key, entry_type, output ready);
endinterface

FILE: rtl/skt_out_if.sv
interface skt_out_if;
  logic                            valid;
  logic                            ready;
  logic [skt_pkg::STATUS_W-1:0]    status;
  logic [skt_pkg::TYPE_W-1:0]      found_type;
  logic [skt_pkg::POS_W-1:0]       position;
  logic [skt_pkg::COUNT_W-1:0]     entry_count;

  modport source (output valid, status, found_type, position, entry_count, input ready);
  modport sink   (input valid, status, found_type, position, entry_count, output ready);
endinterface

FILE: rtl/skt_ctrl.sv
module skt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  skt_pkg::skt_stat_t stat,
  output skt_pkg::skt_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SRCH   = 4'd1;
  localparam logic [3:0] S_CMP    = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_INS_MV = 4'd4;
  localparam logic [3:0] S_INS_WR = 4'd5;
  localparam logic [3:0] S_DEL_MV = 4'd6;
  localparam logic [3:0] S_DEL_WR = 4'd7;
  localparam logic [3:0] S_RESP   = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (stat.srch_more) begin
          cmd.probe_rd = 1'b1;
          state_nxt    = S_CMP;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_CMP: begin
        cmd.probe_upd = 1'b1;
        state_nxt     = S_SRCH;
      end
      S_DECIDE: begin
        cmd.res_set = 1'b1;
        state_nxt   = S_RESP;
        unique case (stat.func) inside
          skt_pkg::FUNC_INSERT: begin
            if (stat.bad_type) begin
              cmd.res_code = skt_pkg::ST_BAD_TYPE;
              cmd.res_sel  = skt_pkg::RSEL_ZERO;
            end else if (stat.hit) begin
              cmd.res_code = skt_pkg::ST_DUPLICATE;
              cmd.res_sel  = skt_pkg::RSEL_PROBE;
            end else if (stat.full) begin
              cmd.res_code = skt_pkg::ST_FULL;
              cmd.res_sel  = skt_pkg::RSEL_ZERO;
            end else begin
              cmd.res_code    = skt_pkg::ST_OK;
              cmd.res_sel     = skt_pkg::RSEL_NEW;
              cmd.mv_init_ins = 1'b1;
              state_nxt       = S_INS_MV;
            end
          end
          skt_pkg::FUNC_REMOVE: begin
            if (!stat.hit) begin
              cmd.res_code = skt_pkg::ST_NOT_FOUND;
              cmd.res_sel  = skt_pkg::RSEL_ZERO;
            end else begin
              cmd.res_code    = skt_pkg::ST_OK;
              cmd.res_sel     = skt_pkg::RSEL_PROBE;
              cmd.mv_init_del = 1'b1;
              state_nxt       = S_DEL_MV;
            end
          end
          skt_pkg::FUNC_LOOKUP, skt_pkg::FUNC_SPARE: begin
            cmd.res_code = stat.hit ? skt_pkg::ST_OK : skt_pkg::ST_NOT_FOUND;
            cmd.res_sel  = stat.hit ? skt_pkg::RSEL_PROBE : skt_pkg::RSEL_ZERO;
          end
          default: begin
            cmd.res_code = skt_pkg::ST_NOT_FOUND;
            cmd.res_sel  = skt_pkg::RSEL_ZERO;
          end
        endcase
      end
      S_INS_MV: begin
        if (stat.ins_more) begin
          cmd.ins_rd = 1'b1;
          state_nxt  = S_INS_WR;
        end else begin
          cmd.new_wr = 1'b1;
          state_nxt  = S_RESP;
        end
      end
      S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = S_INS_MV;
      end
      S_DEL_MV: begin
        if (stat.del_more) begin
          cmd.del_rd = 1'b1;
          state_nxt  = S_DEL_WR;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_DEL_WR: begin
        cmd.del_wr = 1'b1;
        state_nxt  = S_DEL_MV;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/skt_dp.sv
module skt_dp #(
  parameter int TABLE_DEPTH = 256,
  parameter int TYPE_COUNT  = 17
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [skt_pkg::FUNC_W-1:0]     in_func,
  input  logic [skt_pkg::KEY_W-1:0]      in_key,
  input  logic [skt_pkg::TYPE_W-1:0]     in_entry_type,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [skt_pkg::STATUS_W-1:0]   out_status,
  output logic [skt_pkg::TYPE_W-1:0]     out_found_type,
  output logic [skt_pkg::POS_W-1:0]      out_position,
  output logic [skt_pkg::COUNT_W-1:0]    out_entry_count,
  input  skt_pkg::skt_cmd_t              cmd,
  output skt_pkg::skt_stat_t             stat
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = skt_pkg::KEY_W + skt_pkg::TYPE_W;

  // entry = {key, type}
  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          wr_en;

  logic [skt_pkg::FUNC_W-1:0]   op_func_r;
  logic [skt_pkg::KEY_W-1:0]    op_key_r;
  logic [skt_pkg::TYPE_W-1:0]   op_type_r;
  logic [CW-1:0]                lo_r, hi_r, mv_idx_r;
  logic [CW-1:0]                count_r;
  logic                         probe_hit_r;
  logic [skt_pkg::TYPE_W-1:0]   probe_type_r;
  logic [skt_pkg::STATUS_W-1:0] res_status_r;
  logic [skt_pkg::TYPE_W-1:0]   res_type_r;
  logic [CW-1:0]                res_pos_r;
  logic                         out_valid_r;
  logic [skt_pkg::STATUS_W-1:0] out_status_r;
  logic [skt_pkg::TYPE_W-1:0]   out_type_r;
  logic [skt_pkg::POS_W-1:0]    out_pos_r;
  logic [skt_pkg::COUNT_W-1:0]  out_count_r;

  logic [CW-1:0]               mid;
  logic [CW-1:0]               mv_dn, mv_up;
  logic [skt_pkg::KEY_W-1:0]   rd_key;
  logic [skt_pkg::TYPE_W-1:0]  rd_type;
  logic                        probe_lt;
  logic [31:0]                 pos_w, count_w;

  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign mv_dn    = mv_idx_r - CW'(1);
  assign mv_up    = mv_idx_r + CW'(1);
  assign rd_key   = rd_data_r[EW-1:skt_pkg::TYPE_W];
  assign rd_type  = rd_data_r[skt_pkg::TYPE_W-1:0];
  assign probe_lt = rd_key < op_key_r;

  // single read port, single write port
  always_comb begin
    rd_addr = mid[AW-1:0];
    if (cmd.ins_rd) begin
      rd_addr = mv_dn[AW-1:0];
    end else if (cmd.del_rd) begin
      rd_addr = mv_up[AW-1:0];
    end
  end

  always_comb begin
    wr_en   = cmd.ins_wr | cmd.del_wr | cmd.new_wr;
    wr_addr = mv_idx_r[AW-1:0];
    wr_data = rd_data_r;
    if (cmd.new_wr) begin
      wr_addr = lo_r[AW-1:0];
      wr_data = {op_key_r, op_type_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.probe_rd || cmd.ins_rd || cmd.del_rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // search, move and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func_r   <= in_func;
      op_key_r    <= in_key;
      op_type_r   <= in_entry_type;
      lo_r        <= '0;
      hi_r        <= count_r;
      probe_hit_r <= 1'b0;
    end
    if (cmd.probe_upd) begin
      if (probe_lt) begin
        lo_r <= mid + CW'(1);
      end else begin
        hi_r         <= mid;
        probe_hit_r  <= (rd_key == op_key_r);
        probe_type_r <= rd_type;
      end
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_code;
      case (cmd.res_sel)
        skt_pkg::RSEL_PROBE: begin
          res_type_r <= probe_type_r;
          res_pos_r  <= lo_r;
        end
        skt_pkg::RSEL_NEW: begin
          res_type_r <= op_type_r;
          res_pos_r  <= lo_r;
        end
        default: begin
          res_type_r <= '0;
          res_pos_r  <= '0;
        end
      endcase
    end
    if (cmd.mv_init_ins) begin
      mv_idx_r <= count_r;
    end else if (cmd.mv_init_del) begin
      mv_idx_r <= lo_r;
    end else if (cmd.ins_wr) begin
      mv_idx_r <= mv_dn;
    end else if (cmd.del_wr) begin
      mv_idx_r <= mv_up;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_type_r   <= res_type_r;
      out_pos_r    <= pos_w[skt_pkg::POS_W-1:0];
      out_count_r  <= count_w[skt_pkg::COUNT_W-1:0];
    end
  end

  assign pos_w   = 32'(res_pos_r);
  assign count_w = 32'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.new_wr) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat           = '0;
    stat.srch_more = lo_r < hi_r;
    stat.hit       = probe_hit_r;
    stat.bad_type  = {1'b0, op_type_r} >= (skt_pkg::TYPE_W + 1)'(TYPE_COUNT);
    stat.full      = count_r == CW'(TABLE_DEPTH);
    stat.func      = op_func_r;
    stat.ins_more  = mv_idx_r > lo_r;
    stat.del_more  = mv_up < count_r;
    stat.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_type  = out_type_r;
  assign out_position    = out_pos_r;
  assign out_entry_count = out_count_r;

endmodule

FILE: rtl/sorted_key_table_unit.sv
// Per word: a binary search (up to clog2(entries+1) probes, each a read at the midpoint
// and then a window update), a decision, and for an insert or remove that changes the
// table a shift of the entries moved (one read and one write per entry on the one-read,
// one-write table memory). The result then waits for a free output register. A new word
// is taken only once the last result is loaded, also while it waits in the output register.
// Reset (synchronous, rst_n low): entry count zero, output empty, controller idle; table
// memory contents are not cleared, only entries below the count are read.
module sorted_key_table_unit #(
  parameter int TABLE_DEPTH = 256,
  parameter int TYPE_COUNT  = 17
) (
  input  logic      clk,
  input  logic      rst_n,
  skt_in_if.sink    in_ch,
  skt_out_if.source out_ch
);

  skt_pkg::skt_cmd_t  cmd;
  skt_pkg::skt_stat_t stat;

  // Controller: search loop, decision, shift loop, result handoff.
  skt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: sorted table memory, search window, move index, count,
  // and the output register that decouples the result side.
  skt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TYPE_COUNT  (TYPE_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_func         (in_ch.func),
    .in_key          (in_ch.key),
    .in_entry_type   (in_ch.entry_type),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_found_type  (out_ch.found_type),
    .out_position    (out_ch.position),
    .out_entry_count (out_ch.entry_count),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule
